@@ hw/rtl/u16u8_pkg.sv @@
// Shared types and constants for the UTF-16 to UTF-8 escaping transcoder.
package u16u8_pkg;

  localparam int unsigned MaxBytes   = 4;
  localparam int unsigned IdxW       = $clog2(MaxBytes);
  localparam int unsigned CntW       = $clog2(MaxBytes + 1);
  localparam int unsigned QDepth     = 4;
  localparam int unsigned QPtrW      = $clog2(QDepth);
  localparam int unsigned QCntW      = $clog2(QDepth + 1);

  localparam logic [15:0] HighFirst  = 16'hD800;
  localparam logic [15:0] HighLast   = 16'hDBFF;
  localparam logic [15:0] LowFirst   = 16'hDC00;
  localparam logic [15:0] LowLast    = 16'hDFFF;
  localparam logic [15:0] CpTab      = 16'h0009;
  localparam logic [15:0] CpNewline  = 16'h000A;
  localparam logic [15:0] CpReturn   = 16'h000D;
  localparam logic [15:0] CpSpace    = 16'h0020;
  localparam logic [15:0] CpDelete   = 16'h007F;
  localparam logic [15:0] CpTwoByte  = 16'h0080;
  localparam logic [15:0] CpThreeByte = 16'h0800;

  localparam logic [7:0] ByteQuestion  = 8'h3F;
  localparam logic [7:0] ByteBackslash = 8'h5C;
  localparam logic [7:0] ByteLetterT   = 8'h74;
  localparam logic [7:0] ByteLetterN   = 8'h6E;
  localparam logic [7:0] ByteLetterR   = 8'h72;
  localparam logic [7:0] LeadTwo       = 8'hC0;
  localparam logic [7:0] LeadThree     = 8'hE0;
  localparam logic [7:0] LeadFour      = 8'hF0;
  localparam logic [7:0] ContByte      = 8'h80;

  // One classified unit: up to four output bytes, their count and the end flag.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CntW-1:0]          cnt;
    logic                     last;
  } burst_t;

  // Status of the burst queue as seen by its neighbors.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ hw/rtl/utf16_to_utf8_escaping_transcoder.sv @@
// Top level of the UTF-16 to UTF-8 escaping transcoder.
//
// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------
// input    | push_i / full_o      | code_unit_i[15:0], last_unit_i
// result   | empty_o / pop_i      | out_byte_o[7:0], last_byte_o
//
// One code unit is taken every cycle while full_o is low; the front end
// decodes it in the same cycle and writes a burst of up to four bytes into
// a four-entry burst queue. The back end emits one byte per cycle while pop_i
// is high, so the sustained rate is set by the output port and by how many
// bytes each unit yields (none for a held high surrogate, up to four
// otherwise).
// The first byte of a unit shows on the result ports once its burst has
// passed the burst queue and been loaded into the back end's burst register.
// Reset empties the queue and drops any held surrogate; full_o rises only
// while four bursts wait behind the one being emitted.
module utf16_to_utf8_escaping_transcoder import u16u8_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [15:0] code_unit_i,
  input  logic        last_unit_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [7:0]  out_byte_o,
  output logic        last_byte_o
);

  q_status_t q_status;
  burst_t    front_burst;
  burst_t    q_rdata;
  logic      burst_push;
  logic      q_pop;
  logic      accept;

  // Accept whenever the burst queue has room, even if the unit yields no byte.
  assign full_o = q_status.full;
  assign accept = push_i && !q_status.full;

  u16u8_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .code_unit_i  (code_unit_i),
    .last_unit_i  (last_unit_i),
    .burst_push_o (burst_push),
    .burst_o      (front_burst)
  );

  // Decouple decode from byte emission so either side can stall alone.
  u16u8_burst_q u_burst_q (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (burst_push),
    .wdata_i  (front_burst),
    .pop_i    (q_pop),
    .rdata_o  (q_rdata),
    .status_o (q_status)
  );

  // Serialize the current burst; advance to the next one on its final byte.
  u16u8_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .q_rdata_i   (q_rdata),
    .q_pop_o     (q_pop),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .out_byte_o  (out_byte_o),
    .last_byte_o (last_byte_o)
  );

endmodule

@@ hw/rtl/u16u8_front.sv @@
// Front end: accepts code units, pairs surrogates and builds byte bursts.
module u16u8_front import u16u8_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [15:0] code_unit_i,
  input  logic        last_unit_i,
  output logic        burst_push_o,
  output burst_t      burst_o
);

  logic [9:0] pending_high_q, pending_high_d;
  logic       pending_valid_q, pending_valid_d;

  logic        is_high, is_low, pair, prefix;
  logic [20:0] cp;
  logic [2:0][7:0] m;
  logic [CntW-1:0] mcnt;

  assign is_high = (code_unit_i >= HighFirst) && (code_unit_i <= HighLast);
  assign is_low  = (code_unit_i >= LowFirst) && (code_unit_i <= LowLast);
  assign pair    = pending_valid_q && is_low;
  assign prefix  = pending_valid_q && !is_low;
  assign cp      = 21'h10000 + {1'b0, pending_high_q, code_unit_i[9:0]};

  // Bytes for the unit itself, not counting a dropped-hold marker.
  always_comb begin
    m    = '0;
    mcnt = '0;
    if (is_high) begin
      m[0] = ByteQuestion;
      mcnt = last_unit_i ? CntW'(1) : CntW'(0);
    end else if (is_low) begin
      m[0] = ByteQuestion;
      mcnt = CntW'(1);
    end else if (code_unit_i == CpTab) begin
      m[0] = ByteBackslash;
      m[1] = ByteLetterT;
      mcnt = CntW'(2);
    end else if (code_unit_i == CpNewline) begin
      m[0] = ByteBackslash;
      m[1] = ByteLetterN;
      mcnt = CntW'(2);
    end else if (code_unit_i == CpReturn) begin
      m[0] = ByteBackslash;
      m[1] = ByteLetterR;
      mcnt = CntW'(2);
    end else if (code_unit_i < CpSpace || code_unit_i == CpDelete) begin
      m[0] = ByteQuestion;
      mcnt = CntW'(1);
    end else if (code_unit_i < CpTwoByte) begin
      m[0] = {1'b0, code_unit_i[6:0]};
      mcnt = CntW'(1);
    end else if (code_unit_i < CpThreeByte) begin
      m[0] = LeadTwo | {3'b000, code_unit_i[10:6]};
      m[1] = ContByte | {2'b00, code_unit_i[5:0]};
      mcnt = CntW'(2);
    end else begin
      m[0] = LeadThree | {4'b0000, code_unit_i[15:12]};
      m[1] = ContByte | {2'b00, code_unit_i[11:6]};
      m[2] = ContByte | {2'b00, code_unit_i[5:0]};
      mcnt = CntW'(3);
    end
  end

  always_comb begin
    burst_o      = '0;
    burst_o.last = last_unit_i;
    if (pair) begin
      burst_o.bytes[0] = LeadFour | {5'b00000, cp[20:18]};
      burst_o.bytes[1] = ContByte | {2'b00, cp[17:12]};
      burst_o.bytes[2] = ContByte | {2'b00, cp[11:6]};
      burst_o.bytes[3] = ContByte | {2'b00, cp[5:0]};
      burst_o.cnt      = CntW'(4);
    end else if (prefix) begin
      burst_o.bytes[0] = ByteQuestion;
      burst_o.bytes[1] = m[0];
      burst_o.bytes[2] = m[1];
      burst_o.bytes[3] = m[2];
      burst_o.cnt      = mcnt + CntW'(1);
    end else begin
      burst_o.bytes[0] = m[0];
      burst_o.bytes[1] = m[1];
      burst_o.bytes[2] = m[2];
      burst_o.cnt      = mcnt;
    end
  end

  assign burst_push_o = accept_i && (burst_o.cnt != '0);

  always_comb begin
    pending_valid_d = pending_valid_q;
    pending_high_d  = pending_high_q;
    if (accept_i) begin
      pending_valid_d = !pair && is_high && !last_unit_i;
      pending_high_d  = pending_valid_d ? code_unit_i[9:0] : 10'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_valid_q <= 1'b0;
      pending_high_q  <= 10'd0;
    end else begin
      pending_valid_q <= pending_valid_d;
      pending_high_q  <= pending_high_d;
    end
  end

endmodule

@@ hw/rtl/u16u8_burst_q.sv @@
// Short queue of byte bursts between the front and back ends.
module u16u8_burst_q import u16u8_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  burst_t    wdata_i,
  input  logic      pop_i,
  output burst_t    rdata_o,
  output q_status_t status_o
);

  burst_t             mem_q [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]   count_q;
  logic               do_push, do_pop;

  assign status_o.full  = (count_q == QCntW'(QDepth));
  assign status_o.empty = (count_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + QCntW'(1);
        2'b01:   count_q <= count_q - QCntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

@@ hw/rtl/u16u8_back.sv @@
// Back end: holds one burst and hands its bytes out one at a time.
module u16u8_back import u16u8_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  q_status_t q_status_i,
  input  burst_t    q_rdata_i,
  output logic      q_pop_o,
  output logic      empty_o,
  input  logic      pop_i,
  output logic [7:0] out_byte_o,
  output logic      last_byte_o
);

  burst_t          cur_q;
  logic            valid_q, valid_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] final_idx;
  logic            take, done;

  assign final_idx   = IdxW'(cur_q.cnt - CntW'(1));
  assign take        = valid_q && pop_i;
  assign done        = take && (idx_q == final_idx);
  assign q_pop_o     = (!valid_q || done) && !q_status_i.empty;
  assign empty_o     = !valid_q;
  assign out_byte_o  = cur_q.bytes[idx_q];
  assign last_byte_o = cur_q.last && (idx_q == final_idx);

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (q_pop_o) begin
      valid_d = 1'b1;
      idx_d   = '0;
    end else if (done) begin
      valid_d = 1'b0;
      idx_d   = '0;
    end else if (take) begin
      idx_d   = idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_rdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

endmodule

@@ hw/rtl/u16u8_checker.sv @@
// Port-level checks for the transcoder, bound to the top level.
module u16u8_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       full_i,
  input logic       empty_i,
  input logic       pop_i,
  input logic [7:0] out_byte_i,
  input logic       last_byte_i
);

  // Hold the waiting byte while it is not taken.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_i && !pop_i) |=> (!empty_i && $stable(out_byte_i) && $stable(last_byte_i)))
    else $error("result item changed while stalled");

  // The queue cannot fill while the back end sits idle.
  a_full_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(full_i && empty_i))
    else $error("full with no result waiting");

  // A UTF-8 lead byte always has continuation bytes after it.
  a_lead_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_i && out_byte_i[7:6] == 2'b11) |-> !last_byte_i)
    else $error("lead byte flagged as last");

  // The continuation follows a taken lead byte at once.
  a_lead_then_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_i && pop_i && out_byte_i[7:6] == 2'b11) |=>
      (!empty_i && out_byte_i[7:6] == 2'b10))
    else $error("continuation byte missing after lead byte");

endmodule

bind utf16_to_utf8_escaping_transcoder u16u8_checker u_u16u8_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .full_i      (full_o),
  .empty_i     (empty_o),
  .pop_i       (pop_i),
  .out_byte_i  (out_byte_o),
  .last_byte_i (last_byte_o)
);
